@@ src/ogtid_pkg.sv @@
// ----------------------------------------------------------------------------
// ogtid_pkg
// Shared widths, character codes, back end states and result beat layout for
// the one-gap, terminal-gap-ignoring distance unit.
// ----------------------------------------------------------------------------
package ogtid_pkg;

   localparam int CHAR_W          = 8;
   localparam int CUTOFF_W        = 17;
   localparam int DIST_W          = 17;
   localparam int MC_W            = 17;
   localparam int LEN_W           = 16;
   localparam int FRAC_W          = 16;
   localparam int QBITS           = 18;     // quotient bits of the rounded divide
   localparam int QUEUE_DEPTH     = 2;      // finished pairs held between front and back
   localparam int MAX_COLUMNS_DEF = 65536;

   localparam logic [CHAR_W-1:0]   CH_GAP  = 8'h2D;   // '-'
   localparam logic [CHAR_W-1:0]   CH_DOT  = 8'h2E;   // '.'
   localparam logic [DIST_W-1:0]   ONE_Q16 = 17'h10000;
   localparam logic [DIST_W-1:0]   DIST_MAX = 17'h1FFFF;
   localparam logic [MC_W-1:0]     MC_MAX  = 17'h1FFFF;
   localparam logic [LEN_W-1:0]    LEN_MAX = 16'hFFFF;
   localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 17'h10000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CHK,
      ST_DIV,
      ST_OUT
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [MC_W-1:0]   mismatch_count;
      logic [LEN_W-1:0]  effective_length;
      logic              no_overlap;
      logic              over_cutoff;
   } rsp_type;

endpackage

@@ src/ogtid_if.sv @@
// ----------------------------------------------------------------------------
// ogtid channel interfaces
// Column beats in, distance beats out; valid/ready handshake on each.
// ----------------------------------------------------------------------------
interface ogtid_req_if;
   import ogtid_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_a;
   logic [CHAR_W-1:0] char_b;
   logic              is_last;

   modport source (output valid, output char_a, output char_b, output is_last,
                   input ready);
   modport sink   (input valid, input char_a, input char_b, input is_last,
                   output ready);
endinterface

interface ogtid_rsp_if;
   import ogtid_pkg::*;

   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance;
   logic [MC_W-1:0]   mismatch_count;
   logic [LEN_W-1:0]  effective_length;
   logic              no_overlap;
   logic              over_cutoff;

   modport source (output valid, output distance, output mismatch_count,
                   output effective_length, output no_overlap, output over_cutoff,
                   input ready);
   modport sink   (input valid, input distance, input mismatch_count,
                   input effective_length, input no_overlap, input over_cutoff,
                   output ready);
endinterface

@@ src/one_gap_terminal_ignore_distance_unit.sv @@
// ----------------------------------------------------------------------------
// one_gap_terminal_ignore_distance_unit
// Pairwise distance of two aligned sequences, gap runs counted once and
// terminal gaps ignored.
// ----------------------------------------------------------------------------
// Stream one alignment column per beat on req_ch (char_a, char_b, is_last).
// The front end takes a column every clock cycle while the queue is not full
// and needs no gap between pairs; on the column marked is_last it closes the
// pair and posts the committed mismatch count and length into a two-entry
// queue. The back end drains that queue one pair at a time: it fetches the
// pair, does the cutoff multiply, tests it, then runs the bit-serial
// divider for the Q1.16 distance and presents the result beat until rsp_ch
// takes it. A pair settled by the test (no overlap, zero length or over the
// cutoff) skips the divider. The back end fetches no new pair until its
// result beat is taken, so the divider and rsp_ch set the pair rate: a run
// of short pairs fills the queue and req_ch.ready drops until the divider
// catches up. Results come out in pair order, one beat per pair.
// A pair with no anchor column reports distance 1.0 with no_overlap set; a
// pair with a single anchor, or a ratio above the cutoff, reports 1.0 with
// over_cutoff set. Write csr_wr_data (Q1.16 cutoff, reset 1.0) only while
// the unit is idle; the new value applies to pairs finished afterwards.
// Counters saturate at MAX_COLUMNS.
// ----------------------------------------------------------------------------
module one_gap_terminal_ignore_distance_unit #(
   parameter int MAX_COLUMNS = ogtid_pkg::MAX_COLUMNS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   ogtid_req_if.sink                      req_ch,
   ogtid_rsp_if.source                    rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [ogtid_pkg::CUTOFF_W-1:0] csr_wr_data
);
   import ogtid_pkg::*;

   localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
   localparam int JOB_W = 2 * CNT_W + 1;

   logic [CUTOFF_W-1:0] cutoff_ff;

   queue_status_type q_status;
   logic             job_push, job_pop;
   logic [CNT_W-1:0] push_diff, push_len, pop_diff, pop_len;
   logic             push_none, pop_none;
   logic [JOB_W-1:0] push_word, pop_word;
   logic             rsp_valid;
   rsp_type          rsp_data;

   // cutoff register: written whenever the enable is high
   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= CUTOFF_RESET;
      end else if (csr_wr_en) begin
         cutoff_ff <= csr_wr_data;
      end
   end

   ogtid_front #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .q_status (q_status),
      .job_push (job_push),
      .job_diff (push_diff),
      .job_len  (push_len),
      .job_none (push_none)
   );

   assign push_word = {push_none, push_len, push_diff};
   assign pop_diff  = pop_word[CNT_W-1:0];
   assign pop_len   = pop_word[2*CNT_W-1:CNT_W];
   assign pop_none  = pop_word[JOB_W-1];

   ogtid_queue #(
      .DATA_W (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_word),
      .pop       (job_pop),
      .pop_data  (pop_word),
      .status    (q_status)
   );

   ogtid_back #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cutoff    (cutoff_ff),
      .q_status  (q_status),
      .job_diff  (pop_diff),
      .job_len   (pop_len),
      .job_none  (pop_none),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_data  (rsp_data)
   );

   // drive the result beat straight from the back end's output register
   assign rsp_ch.valid            = rsp_valid;
   assign rsp_ch.distance         = rsp_data.distance;
   assign rsp_ch.mismatch_count   = rsp_data.mismatch_count;
   assign rsp_ch.effective_length = rsp_data.effective_length;
   assign rsp_ch.no_overlap       = rsp_data.no_overlap;
   assign rsp_ch.over_cutoff      = rsp_data.over_cutoff;

   // a pair without overlap reports 1.0 and zero counts, never over cutoff
   a_no_overlap_result: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.no_overlap |->
         rsp_ch.distance == ONE_Q16 && !rsp_ch.over_cutoff &&
         rsp_ch.mismatch_count == '0 && rsp_ch.effective_length == '0)
      else $error("no-overlap beat carries counts or cutoff flag");

   // over cutoff always clamps the distance to 1.0
   a_over_is_one: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.over_cutoff |-> rsp_ch.distance == ONE_Q16)
      else $error("over-cutoff beat with distance other than 1.0");

   // the back end only fetches a pair the queue actually holds
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> !q_status.empty)
      else $error("pair fetched from an empty queue");

endmodule

@@ src/ogtid_front.sv @@
// ----------------------------------------------------------------------------
// ogtid_front
// Column classifier: tracks the anchored region, gap runs and the pending
// and committed counters; hands each finished pair to the queue.
// ----------------------------------------------------------------------------
module ogtid_front #(
   parameter int MAX_COLUMNS = ogtid_pkg::MAX_COLUMNS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   ogtid_req_if.sink                            req_ch,
   input  ogtid_pkg::queue_status_type          q_status,
   output logic                                 job_push,
   output logic [$clog2(MAX_COLUMNS+1)-1:0]     job_diff,
   output logic [$clog2(MAX_COLUMNS+1)-1:0]     job_len,
   output logic                                 job_none
);
   import ogtid_pkg::*;

   localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
   localparam logic [CNT_W:0] SAT_MAX = (CNT_W + 1)'(MAX_COLUMNS);

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] x,
                                                input logic [CNT_W-1:0] y);
      logic [CNT_W:0] s;
      s = {1'b0, x} + {1'b0, y};
      return (s > SAT_MAX) ? SAT_MAX[CNT_W-1:0] : s[CNT_W-1:0];
   endfunction

   logic             rs_ff, rs_in;
   logic             ga_ff, ga_in;
   logic             gb_ff, gb_in;
   logic [CNT_W-1:0] cd_ff, cd_in;
   logic [CNT_W-1:0] cl_ff, cl_in;
   logic [CNT_W-1:0] pd_ff, pd_in;
   logic [CNT_W-1:0] pl_ff, pl_in;

   logic gap_a, gap_b, anchor, active, diff, skip, accept;
   logic [CNT_W-1:0] pd_sum, pl_sum;

   assign req_ch.ready = !q_status.full;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      gap_a  = (req_ch.char_a == CH_GAP);
      gap_b  = (req_ch.char_b == CH_GAP);
      anchor = !gap_a && !gap_b && (req_ch.char_a != CH_DOT) && (req_ch.char_b != CH_DOT);
      active = rs_ff || anchor;

      diff  = 1'b0;
      skip  = 1'b0;
      ga_in = ga_ff;
      gb_in = gb_ff;
      if (gap_a && gap_b) begin
         skip = 1'b1;
      end else if (gap_a) begin
         if (!ga_ff) begin
            diff  = 1'b1;
            ga_in = 1'b1;
            gb_in = 1'b0;
         end else begin
            skip = 1'b1;
         end
      end else if (gap_b) begin
         if (!gb_ff) begin
            diff  = 1'b1;
            ga_in = 1'b0;
            gb_in = 1'b1;
         end else begin
            skip = 1'b1;
         end
      end else begin
         ga_in = 1'b0;
         gb_in = 1'b0;
         diff  = (req_ch.char_a != req_ch.char_b);
      end

      pd_sum = sat_add(pd_ff, CNT_W'(diff));
      pl_sum = skip ? pl_ff : sat_add(pl_ff, CNT_W'(1));

      rs_in = active;
      cd_in = cd_ff;
      cl_in = cl_ff;
      pd_in = pd_ff;
      pl_in = pl_ff;
      if (!active) begin
         // outside the region: gap tracking stays put
         ga_in = ga_ff;
         gb_in = gb_ff;
      end else if (!rs_ff) begin
         cd_in = sat_add(cd_ff, CNT_W'(diff));
      end else begin
         pd_in = pd_sum;
         pl_in = pl_sum;
         if (anchor) begin
            // commit trailing columns at each anchor
            cd_in = sat_add(cd_ff, pd_sum);
            cl_in = sat_add(cl_ff, pl_sum);
            pd_in = '0;
            pl_in = '0;
         end
      end
   end

   assign job_push = accept && req_ch.is_last;
   assign job_diff = cd_in;
   assign job_len  = cl_in;
   assign job_none = !rs_in;

   always_ff @(posedge clock) begin
      if (reset || job_push) begin
         rs_ff <= 1'b0;
         ga_ff <= 1'b0;
         gb_ff <= 1'b0;
         cd_ff <= '0;
         cl_ff <= '0;
         pd_ff <= '0;
         pl_ff <= '0;
      end else if (accept) begin
         rs_ff <= rs_in;
         ga_ff <= ga_in;
         gb_ff <= gb_in;
         cd_ff <= cd_in;
         cl_ff <= cl_in;
         pd_ff <= pd_in;
         pl_ff <= pl_in;
      end
   end

endmodule

@@ src/ogtid_queue.sv @@
// ----------------------------------------------------------------------------
// ogtid_queue
// Short FIFO of finished pairs between the classifier and the divider.
// ----------------------------------------------------------------------------
module ogtid_queue #(
   parameter int DATA_W = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [DATA_W-1:0]           push_data,
   input  logic                        pop,
   output logic [DATA_W-1:0]           pop_data,
   output ogtid_pkg::queue_status_type status
);
   import ogtid_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   logic [DATA_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/ogtid_back.sv @@
// ----------------------------------------------------------------------------
// ogtid_back
// Per-pair finisher: cutoff test by one multiply, then a restoring divide
// one quotient bit a cycle, rounded to nearest; holds the result beat.
// ----------------------------------------------------------------------------
module ogtid_back #(
   parameter int MAX_COLUMNS = ogtid_pkg::MAX_COLUMNS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [ogtid_pkg::CUTOFF_W-1:0]        cutoff,
   input  ogtid_pkg::queue_status_type           q_status,
   input  logic [$clog2(MAX_COLUMNS+1)-1:0]      job_diff,
   input  logic [$clog2(MAX_COLUMNS+1)-1:0]      job_len,
   input  logic                                  job_none,
   output logic                                  job_pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output ogtid_pkg::rsp_type                    rsp_data
);
   import ogtid_pkg::*;

   localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
   localparam int EXT_W  = (CNT_W > MC_W) ? CNT_W : MC_W;
   localparam int PROD_W = CNT_W + CUTOFF_W;
   localparam int NUM_W  = CNT_W + FRAC_W + 2;
   localparam int REM_W  = CNT_W + 1;
   localparam int STEP_W = $clog2(QBITS);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QBITS - 1);

   back_state_type state_ff, state_in;

   logic [CNT_W-1:0]  d_ff;
   logic [CNT_W-1:0]  n_ff;
   logic              none_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [REM_W-1:0]  div_ff;
   logic [QBITS-1:0]  num_ff;
   logic [QBITS-1:0]  q_ff;
   logic [STEP_W-1:0] step_ff;
   rsp_type           res_ff;

   logic [EXT_W-1:0]  d_ext, n_ext;
   logic [MC_W-1:0]   d_sat;
   logic [LEN_W-1:0]  n_sat;
   logic              over;
   logic [NUM_W-1:0]  numer;
   logic [REM_W:0]    rem_sh;
   logic              ge;
   logic [QBITS-1:0]  q_fin;

   // saturate reported counts to the port widths
   always_comb begin
      d_ext = EXT_W'(d_ff);
      n_ext = EXT_W'(n_ff);
      d_sat = (d_ext > EXT_W'(MC_MAX)) ? MC_MAX : d_ext[MC_W-1:0];
      n_sat = (n_ext > EXT_W'(LEN_MAX)) ? LEN_MAX : n_ext[LEN_W-1:0];
      over  = (n_ff == '0) || (PROD_W'({d_ff, {FRAC_W{1'b0}}}) > prod_ff);
      // 2*d*2^16 + n over 2*n gives the round-half-up quotient
      numer = NUM_W'({d_ff, {(FRAC_W + 1){1'b0}}}) + NUM_W'(n_ff);
      rem_sh = {rem_ff, num_ff[QBITS-1]};
      ge     = (rem_sh >= {1'b0, div_ff});
      q_fin  = {q_ff[QBITS-2:0], ge};
   end

   always_comb begin
      state_in  = state_ff;
      job_pop   = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               job_pop  = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_CHK;
         end
         ST_CHK: begin
            state_in = (none_ff || over) ? ST_OUT : ST_DIV;
         end
         ST_DIV: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            d_ff    <= job_diff;
            n_ff    <= job_len;
            none_ff <= job_none;
         end
         ST_MUL: begin
            prod_ff <= PROD_W'(cutoff) * PROD_W'(n_ff);
         end
         ST_CHK: begin
            rem_ff  <= REM_W'(numer[NUM_W-1:QBITS]);
            num_ff  <= numer[QBITS-1:0];
            div_ff  <= {n_ff, 1'b0};
            q_ff    <= '0;
            step_ff <= '0;
            res_ff.mismatch_count   <= none_ff ? '0 : d_sat;
            res_ff.effective_length <= none_ff ? '0 : n_sat;
            res_ff.no_overlap       <= none_ff;
            res_ff.over_cutoff      <= !none_ff && over;
            res_ff.distance         <= ONE_Q16;
         end
         ST_DIV: begin
            rem_ff  <= ge ? REM_W'(rem_sh - {1'b0, div_ff}) : rem_sh[REM_W-1:0];
            num_ff  <= {num_ff[QBITS-2:0], 1'b0};
            q_ff    <= q_fin;
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               res_ff.distance <= q_fin[QBITS-1] ? DIST_MAX : q_fin[DIST_W-1:0];
            end
         end
         ST_OUT: begin
            // hold the result beat
         end
         default: begin
         end
      endcase
   end

   assign rsp_data = res_ff;

endmodule

@@ tb/ogtid_distance_checker.sv @@
// ----------------------------------------------------------------------------
// ogtid_distance_checker
// Watches the column and distance channels of the distance unit, predicts the
// distance beat of every finished alignment and compares it field by field.
// ----------------------------------------------------------------------------
module ogtid_distance_checker (
   input  logic                           clock,
   input  logic                           reset,
   ogtid_req_if                           req_mon,
   ogtid_rsp_if                           rsp_mon,
   input  logic                           csr_wr_en,
   input  logic [ogtid_pkg::CUTOFF_W-1:0] csr_wr_data,
   output int                             error_count,
   output int                             beats_outstanding,
   output int                             beats_checked
);
   import ogtid_pkg::*;

   localparam int unsigned COUNT_CAP  = MAX_COLUMNS_DEF;
   localparam int          REPORT_CAP = 60;

   logic [CUTOFF_W-1:0] cutoff_q;
   logic                region_open;
   logic                gap_run_a;
   logic                gap_run_b;
   int unsigned         diffs_kept;
   int unsigned         span_kept;
   int unsigned         diffs_held;
   int unsigned         span_held;
   rsp_type             distance_due[$];
   int                  errors  = 0;
   int                  checked = 0;

   function automatic int unsigned add_capped(int unsigned x, int unsigned y);
      return (x + y > COUNT_CAP) ? COUNT_CAP : x + y;
   endfunction

   task automatic forget_pair();
      region_open = 1'b0;
      gap_run_a   = 1'b0;
      gap_run_b   = 1'b0;
      diffs_kept  = 0;
      span_kept   = 0;
      diffs_held  = 0;
      span_held   = 0;
   endtask

   // Predict the distance beat of the alignment that has just closed.
   task automatic close_pair();
      longint unsigned d;
      longint unsigned n;
      longint unsigned q;
      rsp_type         want;
      d    = diffs_kept;
      n    = span_kept;
      want = '0;
      want.distance   = ONE_Q16;
      want.no_overlap = !region_open;
      if (!region_open) begin
         d = 0;
         n = 0;
      end else if (n == 0 || d * 65536 > longint'(cutoff_q) * n) begin
         want.over_cutoff = 1'b1;
      end else begin
         q = (2 * d * 65536 + n) / (2 * n);
         want.distance = (q > DIST_MAX) ? DIST_MAX : DIST_W'(q);
      end
      want.mismatch_count   = (d > MC_MAX) ? MC_MAX : MC_W'(d);
      want.effective_length = (n > LEN_MAX) ? LEN_MAX : LEN_W'(n);
      distance_due = {distance_due, want};
      forget_pair();
   endtask

   task automatic score_column(logic [CHAR_W-1:0] a, logic [CHAR_W-1:0] b, logic last);
      logic        gap_a;
      logic        gap_b;
      logic        anchor;
      logic        skip;
      int unsigned diff;
      gap_a  = (a == CH_GAP);
      gap_b  = (b == CH_GAP);
      anchor = !gap_a && !gap_b && a != CH_DOT && b != CH_DOT;
      skip   = 1'b0;
      diff   = 0;
      if (region_open || anchor) begin
         if (gap_a && gap_b) begin
            skip = 1'b1;
         end else if (gap_a) begin
            if (gap_run_a) skip = 1'b1;
            else begin
               diff      = 1;
               gap_run_a = 1'b1;
               gap_run_b = 1'b0;
            end
         end else if (gap_b) begin
            if (gap_run_b) skip = 1'b1;
            else begin
               diff      = 1;
               gap_run_a = 1'b0;
               gap_run_b = 1'b1;
            end
         end else begin
            gap_run_a = 1'b0;
            gap_run_b = 1'b0;
            diff      = (a != b);
         end
         // The opening anchor counts its mismatch but adds no length.
         if (!region_open) begin
            region_open = 1'b1;
            diffs_kept  = add_capped(diffs_kept, diff);
         end else begin
            diffs_held = add_capped(diffs_held, diff);
            if (!skip) span_held = add_capped(span_held, 1);
            if (anchor) begin
               diffs_kept = add_capped(diffs_kept, diffs_held);
               span_kept  = add_capped(span_kept, span_held);
               diffs_held = 0;
               span_held  = 0;
            end
         end
      end
      if (last) close_pair();
   endtask

   task automatic note_mismatch(string field, int unsigned want, int unsigned got);
      if (errors < REPORT_CAP)
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      errors++;
   endtask

   task automatic check_beat();
      rsp_type want;
      if (distance_due.size() == 0) begin
         if (errors < REPORT_CAP)
            $display("%0t: distance beat with nothing expected, expected none, got %0d",
                     $time, rsp_mon.distance);
         errors++;
      end else begin
         want = distance_due.pop_front();
         if (rsp_mon.distance !== want.distance)
            note_mismatch("distance", want.distance, rsp_mon.distance);
         if (rsp_mon.mismatch_count !== want.mismatch_count)
            note_mismatch("mismatch_count", want.mismatch_count, rsp_mon.mismatch_count);
         if (rsp_mon.effective_length !== want.effective_length)
            note_mismatch("effective_length", want.effective_length, rsp_mon.effective_length);
         if (rsp_mon.no_overlap !== want.no_overlap)
            note_mismatch("no_overlap", want.no_overlap, rsp_mon.no_overlap);
         if (rsp_mon.over_cutoff !== want.over_cutoff)
            note_mismatch("over_cutoff", want.over_cutoff, rsp_mon.over_cutoff);
      end
      checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cutoff_q = CUTOFF_RESET;
         forget_pair();
         distance_due.delete();
      end else begin
         if (csr_wr_en) cutoff_q = csr_wr_data;
         if (req_mon.valid && req_mon.ready)
            score_column(req_mon.char_a, req_mon.char_b, req_mon.is_last);
         if (rsp_mon.valid && rsp_mon.ready) check_beat();
      end
      error_count       <= errors;
      beats_outstanding <= distance_due.size();
      beats_checked     <= checked;
   end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the one-gap, terminal-gap-ignoring distance unit.
// Directed alignments and about 750 random columns over several cutoff
// settings; a separate checker predicts every distance beat.
// ----------------------------------------------------------------------------
module tb;
   import ogtid_pkg::*;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int RESET_CYCLES    = 11;
   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_COLUMNS   = 150;
   localparam int PHASES          = 5;

   typedef struct packed {
      logic [CHAR_W-1:0] a;
      logic [CHAR_W-1:0] b;
   } column_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_wr_en;
   logic [CUTOFF_W-1:0] csr_wr_data;
   logic                squeeze_req;
   int                  error_count;
   int                  beats_outstanding;
   int                  beats_checked;
   int                  cycle_count     = 0;
   int                  columns_sent    = 0;
   int                  alignments_sent = 0;
   column_type          alignment[$];

   ogtid_req_if req_ch ();
   ogtid_rsp_if rsp_ch ();

   one_gap_terminal_ignore_distance_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ogtid_distance_checker u_check (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_ch),
      .rsp_mon           (rsp_ch),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .error_count       (error_count),
      .beats_outstanding (beats_outstanding),
      .beats_checked     (beats_checked)
   );

   always #5 clock = ~clock;

   // Watchdog: give up well beyond the slowest legal run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic [CHAR_W-1:0] pick_base();
      case ($urandom_range(0, 3))
         0: return "A";
         1: return "C";
         2: return "G";
         default: return "T";
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] pick_byte();
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   // Mostly back-to-back beats, some short gaps, the odd long one.
   function automatic int unsigned pick_gap(logic quiet);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 75) return 0;
      if (r < 93) return $urandom_range(1, 3);
      if (r < 99) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic push_column(logic [CHAR_W-1:0] x, logic [CHAR_W-1:0] y);
      alignment = {alignment, column_type'({x, y})};
   endtask

   // A column that can never be an anchor: a gap or dot on one side at least.
   task automatic push_terminal();
      logic [CHAR_W-1:0] hole;
      logic [CHAR_W-1:0] other;
      hole  = $urandom_range(0, 1) ? CH_GAP : CH_DOT;
      other = $urandom_range(0, 2) == 0 ? CH_GAP : pick_base();
      if ($urandom_range(0, 1)) push_column(hole, other);
      else push_column(other, hole);
   endtask

   task automatic build_alignment(logic short_only);
      int unsigned kind;
      int unsigned body;
      int unsigned run;
      int unsigned r;
      int unsigned i;
      logic [CHAR_W-1:0] x;
      logic [CHAR_W-1:0] y;
      alignment.delete();
      kind = short_only ? 0 : $urandom_range(0, 99);
      if (kind < 75) begin
         // Well formed: terminal gaps, a body with mismatches and gap runs, tail.
         if (short_only) body = $urandom_range(1, 4);
         else if ($urandom_range(0, 99) < 85) body = $urandom_range(1, 12);
         else body = $urandom_range(13, 80);
         if (!short_only && $urandom_range(0, 1)) repeat ($urandom_range(1, 3)) push_terminal();
         i = 0;
         while (i < body) begin
            r = $urandom_range(0, 99);
            if (r < 68) begin
               x = pick_base();
               y = ($urandom_range(0, 3) == 0) ? pick_base() : x;
               push_column(x, y);
            end else if (r < 86) begin
               run = $urandom_range(1, 4);
               x   = CHAR_W'($urandom_range(0, 1));
               repeat (run) begin
                  if (x[0]) push_column(CH_GAP, pick_base());
                  else push_column(pick_base(), CH_GAP);
               end
               i += run - 1;
            end else if (r < 90) begin
               push_column(CH_GAP, CH_GAP);
            end else if (r < 94) begin
               if ($urandom_range(0, 1)) push_column(CH_DOT, pick_base());
               else push_column(pick_base(), CH_DOT);
            end else begin
               push_column(pick_byte(), pick_byte());
            end
            i++;
         end
         if (!short_only && $urandom_range(0, 1)) repeat ($urandom_range(1, 3)) push_terminal();
      end else if (kind < 87) begin
         // Noise: raw bytes with plenty of gaps and dots.
         repeat ($urandom_range(1, 12)) begin
            x = ($urandom_range(0, 9) < 3) ? ($urandom_range(0, 1) ? CH_GAP : CH_DOT)
                                           : pick_byte();
            y = ($urandom_range(0, 9) < 3) ? ($urandom_range(0, 1) ? CH_GAP : CH_DOT)
                                           : pick_byte();
            push_column(x, y);
         end
      end else if (kind < 95) begin
         repeat ($urandom_range(1, 6)) push_terminal();
      end else begin
         push_column(pick_byte(), pick_byte());
      end
   endtask

   // Offer one column beat and hold it until the unit takes it.
   task automatic send_column(logic [CHAR_W-1:0] x, logic [CHAR_W-1:0] y, logic last,
                              int unsigned gap);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.char_a  <= x;
      req_ch.char_b  <= y;
      req_ch.is_last <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      columns_sent++;
   endtask

   task automatic send_alignment(logic quiet);
      for (int i = 0; i < alignment.size(); i++)
         send_column(alignment[i].a, alignment[i].b, i == alignment.size() - 1, pick_gap(quiet));
      alignments_sent++;
   endtask

   // Drop valid and wait for every outstanding distance beat, then let the
   // back end go quiet before anything else happens.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (beats_outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_cutoff(logic [CUTOFF_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Result side: random stalls, stretches of constant ready, and a single long
   // hold-off once the sender starts its burst of short alignments.
   initial begin
      int unsigned r;
      int unsigned span;
      logic        held_once;
      held_once    = 1'b0;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (squeeze_req && !held_once) begin
            held_once = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               rsp_ch.ready <= 1'b1;
               span = $urandom_range(1, 30);
            end else if (r < 62) begin
               rsp_ch.ready <= 1'b1;
               span = $urandom_range(100, 200);
            end else if (r < 95) begin
               rsp_ch.ready <= 1'b0;
               span = $urandom_range(1, 4);
            end else begin
               rsp_ch.ready <= 1'b0;
               span = $urandom_range(15, 60);
            end
            repeat (span) @(posedge clock);
         end
      end
   end

   // Column side: directed alignments, then random phases.
   initial begin
      logic [CUTOFF_W-1:0] cut_plan[PHASES];
      int                  phase_start;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.char_a  = '0;
      req_ch.char_b  = '0;
      req_ch.is_last = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      squeeze_req    = 1'b0;
      cut_plan[0]    = '0;
      cut_plan[1]    = CUTOFF_W'($urandom_range(1, 65535));
      cut_plan[2]    = ONE_Q16;
      cut_plan[3]    = 17'd32768;
      cut_plan[4]    = CUTOFF_W'($urandom_range(0, 65536));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      write_cutoff(ONE_Q16);

      // No anchor anywhere: gaps and dots only.
      alignment.delete();
      push_column(CH_DOT, CH_GAP);
      push_column(CH_GAP, CH_GAP);
      send_alignment(1'b1);
      // A lone anchor gives zero length.
      alignment.delete();
      push_column("A", "A");
      send_alignment(1'b1);
      // Leading gap, mismatch, gap run opened and continued, gap in the other
      // sequence, gap-gap column, dot opposite a base, anchor, trailing gaps.
      alignment.delete();
      push_column(CH_GAP, "A");
      push_column("A", "A");
      push_column("C", "G");
      push_column(CH_GAP, "T");
      push_column(CH_GAP, "T");
      push_column("A", CH_GAP);
      push_column(CH_GAP, CH_GAP);
      push_column(CH_DOT, "A");
      push_column("G", "G");
      push_column("T", CH_GAP);
      push_column(CH_GAP, CH_GAP);
      send_alignment(1'b0);
      // Extreme byte values act as ordinary characters.
      alignment.delete();
      push_column(8'h00, 8'hFF);
      push_column(8'hFF, 8'hFF);
      push_column(8'h00, 8'h00);
      send_alignment(1'b0);
      settle();

      for (int p = 0; p < PHASES; p++) begin
         write_cutoff(cut_plan[p]);
         phase_start = columns_sent;
         // In the squeeze phase short alignments pile up behind the hold-off.
         if (p == 2) squeeze_req <= 1'b1;
         while (columns_sent - phase_start < PHASE_COLUMNS) begin
            build_alignment(p == 2);
            send_alignment(p == 2 || $urandom_range(0, 3) == 0);
         end
         settle();
      end

      $display("Checked %0d distance beats from %0d alignments, %0d columns in all.",
               beats_checked, alignments_sent, columns_sent);
      $display("Cutoffs 0 to 1.0, gap runs, terminal gaps and a %0d-cycle result hold-off.",
               HOLD_OFF_CYCLES);
      if (error_count == 0 && beats_outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ one_gap_terminal_ignore_distance_unit.f @@
src/ogtid_pkg.sv
src/ogtid_if.sv
src/ogtid_front.sv
src/ogtid_queue.sv
src/ogtid_back.sv
src/one_gap_terminal_ignore_distance_unit.sv
tb/ogtid_distance_checker.sv
tb/tb.sv
